// ----- design/gct_pkg.sv -----
`timescale 1ns / 1ps

package gct_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int GAS_W       = 32;
  localparam int SPREAD_W    = 17;
  localparam int SPREAD_SH   = 16;
  localparam int FILL_W      = 5;
  localparam int FILL_MAX    = 31;
  localparam int SUM_W       = GAS_W + IDX_W;
  localparam int NUM_W       = (SUM_W > GAS_W + SPREAD_SH) ? SUM_W : GAS_W + SPREAD_SH;
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
  localparam int CNT_EXT_W   = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  localparam logic [SPREAD_W-1:0] SPREAD_ONE = SPREAD_W'(65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_MIN,
    ST_WRITE,
    ST_SCAN_SUM,
    ST_EVAL,
    ST_DIV_SPREAD,
    ST_DIV_MEAN,
    ST_DONE
  } gct_state_e;

endpackage

// ----- design/gas_ceiling_tracker.sv -----
`timescale 1ns / 1ps
// Each reading is handled in order: a walk of the table through its single read port
// to find the least entry, the table write, a second walk to sum the entries, then a
// one-bit-per-cycle divider used twice (spread, then mean), skipped when the table ends
// up empty. No new reading is taken until the last result is in the output register.
// Reset: table entries read as empty, write pointer 0, held ceiling 0, held spread 65536.

module gas_ceiling_tracker
  import gct_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [GAS_W-1:0]    gas_value_i,
  input  logic                command_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [GAS_W-1:0]    ceiling_o,
  output logic [SPREAD_W-1:0] spread_fraction_o,
  output logic [FILL_W-1:0]   filled_entries_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  gct_state_e state_q, state_d;

  logic [GAS_W-1:0]     mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_q, vld_d;
  logic [GAS_W-1:0]     rd_data_q;
  logic                 rd_hit_q;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [GAS_W-1:0]     rd_val;

  logic [IDX_W:0]       scan_q, scan_d;
  logic                 proc_q;
  logic [IDX_W-1:0]     proc_idx_q;

  logic [GAS_W-1:0]     reading_q, reading_d;
  logic                 cmd_q, cmd_d;
  logic [IDX_W-1:0]     wp_q, wp_d;
  logic [GAS_W-1:0]     least_q, least_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic                 last_nz_q, last_nz_d;

  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [GAS_W-1:0]     lo_q, lo_d;
  logic [GAS_W-1:0]     hi_q, hi_d;

  logic [NUM_W-1:0]     num_q, num_d;
  logic [GAS_W-1:0]     rem_q, rem_d;
  logic [GAS_W-1:0]     dvsr_q, dvsr_d;
  logic [DIV_CNT_W-1:0] dcnt_q, dcnt_d;
  logic [GAS_W:0]       rem_sh;
  logic                 div_ge;
  logic [GAS_W-1:0]     rem_nx;
  logic [NUM_W-1:0]     quo_nx;

  logic [GAS_W-1:0]     ceil_q, ceil_d;
  logic [SPREAD_W-1:0]  spread_q, spread_d;

  logic                 out_valid_q, out_valid_d;
  logic [GAS_W-1:0]     out_ceil_q, out_ceil_d;
  logic [SPREAD_W-1:0]  out_spread_q, out_spread_d;
  logic [FILL_W-1:0]    out_fill_q, out_fill_d;
  logic [CNT_EXT_W-1:0] cnt_ext;
  logic [FILL_W-1:0]    fill_sat;

  assign rd_val  = rd_hit_q ? rd_data_q : '0;
  assign rd_addr = scan_q[IDX_W-1:0];
  assign rd_en   = ((state_q == ST_SCAN_MIN) || (state_q == ST_SCAN_SUM)) &&
                   (scan_q < (IDX_W + 1)'(TABLE_DEPTH));

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign div_ge = rem_sh >= {1'b0, dvsr_q};
  assign rem_nx = div_ge ? GAS_W'(rem_sh - {1'b0, dvsr_q}) : rem_sh[GAS_W-1:0];
  assign quo_nx = {num_q[NUM_W-2:0], div_ge};

  assign cnt_ext  = CNT_EXT_W'(cnt_q);
  assign fill_sat = (cnt_ext > CNT_EXT_W'(FILL_MAX)) ? FILL_W'(FILL_MAX) : FILL_W'(cnt_ext);

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign ceiling_o         = out_ceil_q;
  assign spread_fraction_o = out_spread_q;
  assign filled_entries_o  = out_fill_q;

  always_comb begin
    state_d      = state_q;
    vld_d        = vld_q;
    scan_d       = scan_q;
    reading_d    = reading_q;
    cmd_d        = cmd_q;
    wp_d         = wp_q;
    least_d      = least_q;
    pos_d        = pos_q;
    last_nz_d    = last_nz_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    num_d        = num_q;
    rem_d        = rem_q;
    dvsr_d       = dvsr_q;
    dcnt_d       = dcnt_q;
    ceil_d       = ceil_q;
    spread_d     = spread_q;
    out_ceil_d   = out_ceil_q;
    out_spread_d = out_spread_q;
    out_fill_d   = out_fill_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_we       = 1'b0;
    mem_waddr    = wp_q;

    if (rd_en) begin
      scan_d = scan_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          reading_d = gas_value_i;
          cmd_d     = command_i;
          scan_d    = '0;
          state_d   = ST_SCAN_MIN;
        end
      end
      ST_SCAN_MIN: begin
        if (proc_q) begin
          if ((proc_idx_q == '0) || (rd_val < least_q)) begin
            least_d = rd_val;
            pos_d   = proc_idx_q;
          end
          if (proc_idx_q == LAST_IDX) begin
            last_nz_d = (rd_val != '0);
            state_d   = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        if (cmd_q && last_nz_q) begin
          mem_waddr = pos_q;
          mem_we    = (reading_q > least_q);
        end else begin
          mem_waddr = wp_q;
          mem_we    = 1'b1;
          wp_d      = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
        end
        if (mem_we) begin
          vld_d[mem_waddr] = 1'b1;
        end
        scan_d  = '0;
        sum_d   = '0;
        cnt_d   = '0;
        lo_d    = '0;
        hi_d    = '0;
        state_d = ST_SCAN_SUM;
      end
      ST_SCAN_SUM: begin
        if (proc_q) begin
          if (rd_val != '0) begin
            sum_d = sum_q + SUM_W'(rd_val);
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == '0) begin
              lo_d = rd_val;
              hi_d = rd_val;
            end else begin
              if (rd_val < lo_q) lo_d = rd_val;
              if (rd_val > hi_q) hi_d = rd_val;
            end
          end
          if (proc_idx_q == LAST_IDX) begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          num_d   = NUM_W'({GAS_W'(hi_q - lo_q), SPREAD_SH'(0)});
          rem_d   = '0;
          dvsr_d  = hi_q;
          dcnt_d  = DIV_CNT_W'(NUM_W);
          state_d = ST_DIV_SPREAD;
        end
      end
      ST_DIV_SPREAD: begin
        num_d  = quo_nx;
        rem_d  = rem_nx;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DIV_CNT_W'(1)) begin
          spread_d = SPREAD_W'(quo_nx);
          num_d    = NUM_W'(sum_q);
          rem_d    = '0;
          dvsr_d   = GAS_W'(cnt_q);
          dcnt_d   = DIV_CNT_W'(NUM_W);
          state_d  = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        num_d  = quo_nx;
        rem_d  = rem_nx;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DIV_CNT_W'(1)) begin
          ceil_d  = GAS_W'(quo_nx);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_ceil_d   = ceil_q;
          out_spread_d = spread_q;
          out_fill_d   = fill_sat;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= reading_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      rd_hit_q    <= 1'b0;
      proc_q      <= 1'b0;
      proc_idx_q  <= '0;
      scan_q      <= '0;
      wp_q        <= '0;
      dcnt_q      <= '0;
      ceil_q      <= '0;
      spread_q    <= SPREAD_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      proc_q      <= rd_en;
      scan_q      <= scan_d;
      wp_q        <= wp_d;
      dcnt_q      <= dcnt_d;
      ceil_q      <= ceil_d;
      spread_q    <= spread_d;
      out_valid_q <= out_valid_d;
      if (rd_en) begin
        rd_hit_q   <= vld_q[rd_addr];
        proc_idx_q <= rd_addr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    reading_q    <= reading_d;
    cmd_q        <= cmd_d;
    least_q      <= least_d;
    pos_q        <= pos_d;
    last_nz_q    <= last_nz_d;
    sum_q        <= sum_d;
    cnt_q        <= cnt_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    num_q        <= num_d;
    rem_q        <= rem_d;
    dvsr_q       <= dvsr_d;
    out_ceil_q   <= out_ceil_d;
    out_spread_q <= out_spread_d;
    out_fill_q   <= out_fill_d;
  end

endmodule

// ----- tb/sv/gas_ceiling_tracker_test.sv -----
`timescale 1ns / 1ps

module gas_ceiling_tracker_test;
  import gct_pkg::*;

  localparam int ITEM_TARGET    = 950;
  localparam int IDLE_PCT       = 37;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [GAS_W-1:0]    ceiling;
    logic [SPREAD_W-1:0] spread;
    logic [FILL_W-1:0]   filled;
  } tracker_result_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic [GAS_W-1:0]    gas_value   = '0;
  logic                command     = 1'b0;
  logic                out_ready   = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [GAS_W-1:0]    ceiling;
  logic [SPREAD_W-1:0] spread_fraction;
  logic [FILL_W-1:0]   filled_entries;

  logic [GAS_W-1:0]    readings [TABLE_DEPTH];
  int unsigned         wr_ptr;
  logic [GAS_W-1:0]    held_ceiling;
  logic [SPREAD_W-1:0] held_spread;
  tracker_result_t     expected_results [$];
  tracker_result_t     oldest_result;

  bit          idle_en  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left;
  int unsigned stall_cycles;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned replace_cmds;
  int unsigned replace_hits;
  int unsigned empty_results;

  gas_ceiling_tracker i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .gas_value_i       (gas_value),
    .command_i         (command),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .ceiling_o         (ceiling),
    .spread_fraction_o (spread_fraction),
    .filled_entries_o  (filled_entries)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic predict_ceiling(input logic [GAS_W-1:0] reading, input logic replace);
    int unsigned     slot;
    int unsigned     count;
    logic [GAS_W-1:0] least;
    logic [GAS_W-1:0] lo;
    logic [GAS_W-1:0] hi;
    logic [63:0]     total;
    logic [63:0]     numer;
    tracker_result_t res;
    slot  = 0;
    count = 0;
    lo    = '0;
    hi    = '0;
    total = '0;
    if (replace) replace_cmds++;
    if (replace && readings[TABLE_DEPTH-1] != '0) begin
      least = readings[0];
      for (int k = 1; k < TABLE_DEPTH; k++) begin
        if (readings[k] < least) begin
          least = readings[k];
          slot  = k;
        end
      end
      if (reading > least) begin
        readings[slot] = reading;
        replace_hits++;
      end
    end else begin
      readings[wr_ptr] = reading;
      wr_ptr = (wr_ptr == TABLE_DEPTH - 1) ? 0 : wr_ptr + 1;
    end
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (readings[k] != '0) begin
        total = total + 64'(readings[k]);
        if (count == 0) begin
          lo = readings[k];
          hi = readings[k];
        end else begin
          if (readings[k] < lo) lo = readings[k];
          if (readings[k] > hi) hi = readings[k];
        end
        count++;
      end
    end
    if (count != 0) begin
      numer        = 64'(hi - lo) << SPREAD_SH;
      held_spread  = SPREAD_W'(numer / 64'(hi));
      held_ceiling = GAS_W'(total / 64'(count));
    end else begin
      empty_results++;
    end
    res.ceiling = held_ceiling;
    res.spread  = held_spread;
    res.filled  = (count > FILL_MAX) ? FILL_W'(FILL_MAX) : FILL_W'(count);
    expected_results.push_back(res);
    items_sent++;
  endtask

  task automatic send_reading(input logic [GAS_W-1:0] reading, input logic replace);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      if ($urandom_range(39) == 0) repeat ($urandom_range(1, 200)) @(negedge clk_i);
      else @(negedge clk_i);
    end
    in_valid  = 1'b1;
    gas_value = reading;
    command   = replace;
    do @(posedge clk_i); while (!in_ready);
    predict_ceiling(reading, replace);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [GAS_W-1:0] pick_reading();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return GAS_W'($urandom_range(1, 20));
      4:       return GAS_W'($urandom_range(32'hFFFF_FFFF, 32'hFFFF_FF00));
      default: return GAS_W'($urandom);
    endcase
  endfunction

  // ready side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        out_ready = 1'b0;
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end else begin
        out_ready = !idle_en || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", stall_cycles);
        $display("== FAIL ==");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: ceiling %0d spread %0d filled %0d",
                 ceiling, spread_fraction, filled_entries);
          errors++;
        end else begin
          oldest_result = expected_results.pop_front();
          results_checked++;
          if (ceiling !== oldest_result.ceiling) begin
            $error("ceiling: expected %0d, got %0d", oldest_result.ceiling, ceiling);
            errors++;
          end
          if (spread_fraction !== oldest_result.spread) begin
            $error("spread_fraction: expected %0d, got %0d",
                   oldest_result.spread, spread_fraction);
            errors++;
          end
          if (filled_entries !== oldest_result.filled) begin
            $error("filled_entries: expected %0d, got %0d",
                   oldest_result.filled, filled_entries);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_empty_start();
    send_reading('0, 1'b0);
    send_reading('1, 1'b1);
    send_reading(GAS_W'(1), 1'b0);
  endtask

  task automatic test_fill_extremes();
    logic [GAS_W-1:0] fill_vals [13] = '{
      32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF,
      32'hFFFF_0000, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0002, 32'h1234_5678,
      32'hFFFF_FFFE, 32'h0000_0003, 32'hFFFF_FFFF};
    foreach (fill_vals[k]) send_reading(fill_vals[k], 1'b0);
  endtask

  task automatic test_replace_rules();
    send_reading('0, 1'b1);
    send_reading(GAS_W'(2), 1'b1);
    send_reading(GAS_W'(1), 1'b1);
    send_reading('1, 1'b1);
    send_reading('0, 1'b0);
  endtask

  task automatic test_wipe_and_refill();
    for (int k = 0; k < TABLE_DEPTH; k++) send_reading('0, 1'b0);
    send_reading('0, 1'b1);
    for (int k = 0; k < TABLE_DEPTH + 4; k++) send_reading(pick_reading(), 1'($urandom));
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    for (int k = 0; k < 60; k++) send_reading(pick_reading(), 1'($urandom));
    idle_en = 1'b1;
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    for (int k = 0; k < 8; k++) send_reading(pick_reading(), 1'($urandom));
    wait_for_results();
  endtask

  task automatic test_sender_pause();
    for (int k = 0; k < 10; k++) send_reading(pick_reading(), 1'b1);
    wait_for_results();
    for (int k = 0; k < 10; k++) send_reading(pick_reading(), 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned run;
    while (items_sent < ITEM_TARGET) begin
      run = $urandom_range(1, 20);
      case ($urandom_range(9))
        0:          for (int k = 0; k < TABLE_DEPTH; k++) send_reading('0, 1'b0);
        1, 2, 3:    repeat (run) send_reading(pick_reading(), 1'b0);
        4, 5, 6, 7: repeat (run) send_reading(pick_reading(), 1'b1);
        8:          repeat (run) send_reading(GAS_W'($urandom), 1'($urandom));
        default:    repeat (run) send_reading(GAS_W'($urandom_range(1, 6)), 1'($urandom));
      endcase
    end
  endtask

  initial begin
    for (int k = 0; k < TABLE_DEPTH; k++) readings[k] = '0;
    wr_ptr       = 0;
    held_ceiling = '0;
    held_spread  = SPREAD_ONE;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_start();
    test_fill_extremes();
    test_replace_rules();
    test_wipe_and_refill();
    test_back_to_back();
    test_output_stall();
    test_sender_pause();
    test_random_traffic();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d readings, checked %0d results; %0d replace commands, %0d took effect.",
             items_sent, results_checked, replace_cmds, replace_hits);
    $display("Saw %0d results from an empty table, one long output stall and one drained pause.",
             empty_results);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/gct_pkg.sv
design/gas_ceiling_tracker.sv
tb/sv/gas_ceiling_tracker_test.sv
